>>> src/fpba_pkg.sv
// Shared constants, codes and types of the fit-policy block allocator.
package fpba_pkg;

  // Storage shape
  localparam int BLOCKS    = 16;
  localparam int SIZE_BITS = 16;

  // Port field widths
  localparam int TYPE_W    = 1;
  localparam int BIDX_W    = 4;
  localparam int PSIZE_W   = 16;
  localparam int POLICY_W  = 2;
  localparam int BCOUNT_W  = 5;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DAT_W = 5;

  // Derived widths
  localparam int IDX_W    = $clog2(BLOCKS);
  localparam int WR_IDX_W = (IDX_W > BIDX_W) ? IDX_W : BIDX_W;
  localparam int CNT_W    = (IDX_W > BCOUNT_W) ? IDX_W : BCOUNT_W;

  // Fit policy codes (code three acts as first fit)
  localparam logic [POLICY_W-1:0] POLICY_FIRST = 2'd0;
  localparam logic [POLICY_W-1:0] POLICY_BEST  = 2'd1;
  localparam logic [POLICY_W-1:0] POLICY_WORST = 2'd2;

  // Request type codes
  localparam logic [TYPE_W-1:0] REQ_LOAD  = 1'b0;
  localparam logic [TYPE_W-1:0] REQ_ALLOC = 1'b1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FIT_POLICY  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  // Reset values of the configuration registers
  localparam logic [POLICY_W-1:0] POLICY_RST = POLICY_FIRST;
  localparam logic [BCOUNT_W-1:0] BCOUNT_RST = 5'd16;

  // Scan token handed from cell to cell
  typedef struct packed {
    logic                  valid;
    logic                  found;
    logic [IDX_W-1:0]      pick;
    logic [SIZE_BITS-1:0]  best;
    logic [SIZE_BITS-1:0]  req;
    logic [POLICY_W-1:0]   policy;
    logic [CNT_W-1:0]      count;
  } tok_t;

  // Write broadcast to the cells
  typedef struct packed {
    logic                  en;
    logic [WR_IDX_W-1:0]   idx;
    logic [SIZE_BITS-1:0]  data;
  } wr_t;

endpackage

>>> src/fpba_cell.sv
// One allocator cell: holds the free space of one block and updates the scan token.
module fpba_cell (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic [fpba_pkg::IDX_W-1:0] cell_idx_i,
  input  fpba_pkg::wr_t            wr_i,
  input  fpba_pkg::tok_t           tok_i,
  output fpba_pkg::tok_t           tok_o
);
  import fpba_pkg::*;

  logic [SIZE_BITS-1:0] space_q;
  tok_t                 tok_q, tok_d;
  logic                 fits;
  logic                 take;

  always_ff @(posedge clk_i) begin
    if (wr_i.en && (wr_i.idx == WR_IDX_W'(cell_idx_i))) begin
      space_q <= wr_i.data;
    end
  end

  always_comb begin
    fits = tok_i.valid && (CNT_W'(cell_idx_i) < tok_i.count) && (space_q >= tok_i.req);
    take = fits && (!tok_i.found ||
                    ((tok_i.policy == POLICY_BEST)  && (space_q < tok_i.best)) ||
                    ((tok_i.policy == POLICY_WORST) && (space_q > tok_i.best)));
    tok_d       = tok_i;
    tok_d.found = tok_i.found | fits;
    if (take) begin
      tok_d.pick = cell_idx_i;
      tok_d.best = space_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

>>> src/fit_policy_block_allocator.sv
// Fit-policy block allocator: a row of block cells swept by an allocation token.
//
// Each cell holds the free space of one block. A load request writes one cell and
// returns its result in the next cycle. An allocate request launches a token into
// cell 0; it moves one cell per cycle. When it leaves the last cell, the subtraction
// is committed to the chosen cell and the result is captured in hold registers; it
// moves to the output register once that is free, one request at a time. A request
// is taken only while no allocate is in flight and the output register is free or
// being drained. Blocks must be loaded before an allocate reads them.
module fit_policy_block_allocator (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [fpba_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [fpba_pkg::CFG_DAT_W-1:0] cfg_data_i,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  logic [fpba_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [fpba_pkg::BIDX_W-1:0]  block_index_i,
  input  logic [fpba_pkg::PSIZE_W-1:0] size_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output logic                         granted_o,
  output logic [fpba_pkg::BIDX_W-1:0]  chosen_block_o,
  output logic [fpba_pkg::PSIZE_W-1:0] space_left_o
);
  import fpba_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0]           state_q, state_d;
  logic [POLICY_W-1:0]  policy_q;
  logic [BCOUNT_W-1:0]  count_q;

  logic                 out_valid_q, out_valid_d;
  logic                 granted_q, granted_d;
  logic [BIDX_W-1:0]    chosen_q, chosen_d;
  logic [PSIZE_W-1:0]   space_left_q, space_left_d;

  logic                 hold_granted_q;
  logic [IDX_W-1:0]     hold_pick_q;
  logic [SIZE_BITS-1:0] hold_space_q;

  logic                 out_free;
  logic                 accept;
  logic                 accept_load;
  logic                 accept_alloc;
  logic [SIZE_BITS-1:0] req;
  logic [SIZE_BITS-1:0] remain;
  logic                 sweep_done;

  tok_t                 tok [BLOCKS+1];
  wr_t                  wr;

  assign out_free     = !out_valid_q || !out_stall_i;
  assign in_stall_o   = (state_q != ST_IDLE) || !out_free;
  assign accept       = in_valid_i && !in_stall_o;
  assign accept_load  = accept && (req_type_i == REQ_LOAD);
  assign accept_alloc = accept && (req_type_i == REQ_ALLOC);
  assign req          = SIZE_BITS'(size_i);
  assign sweep_done   = tok[BLOCKS].valid;
  assign remain       = tok[BLOCKS].best - tok[BLOCKS].req;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= POLICY_RST;
      count_q  <= BCOUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FIT_POLICY:  policy_q <= POLICY_W'(cfg_data_i);
        CFG_BLOCK_COUNT: count_q  <= BCOUNT_W'(cfg_data_i);
        default: ;
      endcase
    end
  end

  // Launch token
  always_comb begin
    tok[0].valid  = accept_alloc;
    tok[0].found  = 1'b0;
    tok[0].pick   = '0;
    tok[0].best   = '0;
    tok[0].req    = req;
    tok[0].policy = policy_q;
    tok[0].count  = CNT_W'(count_q);
  end

  // Load writes at acceptance; a granted sweep commits the subtraction.
  always_comb begin
    wr.en   = 1'b0;
    wr.idx  = WR_IDX_W'(block_index_i);
    wr.data = req;
    if (sweep_done) begin
      wr.en   = tok[BLOCKS].found;
      wr.idx  = WR_IDX_W'(tok[BLOCKS].pick);
      wr.data = remain;
    end else if (accept_load) begin
      wr.en = 1'b1;
    end
  end

  for (genvar k = 0; k < BLOCKS; k++) begin : g_cell
    fpba_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .cell_idx_i (IDX_W'(k)),
      .wr_i       (wr),
      .tok_i      (tok[k]),
      .tok_o      (tok[k+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (sweep_done) begin
      hold_granted_q <= tok[BLOCKS].found;
      hold_pick_q    <= tok[BLOCKS].found ? tok[BLOCKS].pick : '0;
      hold_space_q   <= tok[BLOCKS].found ? remain : '0;
    end
  end

  always_comb begin
    state_d      = state_q;
    out_valid_d  = out_valid_q;
    granted_d    = granted_q;
    chosen_d     = chosen_q;
    space_left_d = space_left_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (accept_load) begin
          out_valid_d  = 1'b1;
          granted_d    = 1'b0;
          chosen_d     = '0;
          space_left_d = PSIZE_W'(req);
        end else if (accept_alloc) begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (sweep_done) begin
          state_d = ST_HOLD;
        end
      end
      ST_HOLD: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          granted_d    = hold_granted_q;
          chosen_d     = BIDX_W'(hold_pick_q);
          space_left_d = PSIZE_W'(hold_space_q);
          state_d      = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    granted_q    <= granted_d;
    chosen_q     <= chosen_d;
    space_left_q <= space_left_d;
  end

  assign out_valid_o    = out_valid_q;
  assign granted_o      = granted_q;
  assign chosen_block_o = chosen_q;
  assign space_left_o   = space_left_q;

endmodule

>>> src/fpba_checker.sv
// Port-level checks of the fit-policy block allocator, bound to the top level.
module fpba_checker (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_stall_o,
  input  logic [fpba_pkg::TYPE_W-1:0]  req_type_i,
  input  logic [fpba_pkg::PSIZE_W-1:0] size_i,
  input  logic                         out_valid_o,
  input  logic                         out_stall_i,
  input  logic                         granted_o,
  input  logic [fpba_pkg::BIDX_W-1:0]  chosen_block_o,
  input  logic [fpba_pkg::PSIZE_W-1:0] space_left_o
);
  import fpba_pkg::*;

  // Hold a stalled result.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(granted_o) &&
      $stable(chosen_block_o) && $stable(space_left_o))
    else $error("stalled result changed");

  // A result without a grant (a refused allocate or a load) reports block zero.
  a_no_grant_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !granted_o |-> chosen_block_o == '0)
    else $error("refused result names a block");

  // An accepted allocate blocks further requests while it sweeps.
  a_alloc_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_ALLOC) |=> in_stall_o)
    else $error("request taken during a sweep");

  // A load answers in the next cycle with the loaded size.
  a_load_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && (req_type_i == REQ_LOAD) |=>
      out_valid_o && !granted_o && (space_left_o == PSIZE_W'(SIZE_BITS'($past(size_i)))))
    else $error("load result wrong");

endmodule

bind fit_policy_block_allocator fpba_checker u_fpba_checker (.*);

>>> test/testbench.sv
// Testbench for the fit-policy block allocator: directed and random requests checked against a predictor.
`timescale 1ns / 1ps

module testbench;
  import fpba_pkg::*;

  localparam logic [POLICY_W-1:0] POLICY_ALT = 2'd3;  // spare code, acts as first fit
  localparam int PHASES        = 12;
  localparam int PHASE_ITEMS   = 52;
  localparam int SETTLE_CYCLES = BLOCKS + 4;

  typedef struct packed {
    logic                 granted;
    logic [BIDX_W-1:0]    chosen_block;
    logic [PSIZE_W-1:0]   space_left;
  } grant_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DAT_W-1:0]  cfg_data = '0;
  logic                  in_valid = 1'b0;
  logic                  in_stall;
  logic [TYPE_W-1:0]     req_type = '0;
  logic [BIDX_W-1:0]     block_index = '0;
  logic [PSIZE_W-1:0]    size = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic                  granted;
  logic [BIDX_W-1:0]     chosen_block;
  logic [PSIZE_W-1:0]    space_left;

  // predictor state
  logic [SIZE_BITS-1:0]  space_model [BLOCKS];
  logic [POLICY_W-1:0]   policy_model = POLICY_RST;
  logic [BCOUNT_W-1:0]   count_model = BCOUNT_RST;
  grant_t                grant_q [$];

  int                    mismatch_count = 0;
  bit                    gaps_on = 1'b1;
  bit                    stall_on = 1'b1;

  fit_policy_block_allocator u_top (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .cfg_we_i       (cfg_we),
    .cfg_idx_i      (cfg_idx),
    .cfg_data_i     (cfg_data),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .req_type_i     (req_type),
    .block_index_i  (block_index),
    .size_i         (size),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .granted_o      (granted),
    .chosen_block_o (chosen_block),
    .space_left_o   (space_left)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    out_stall <= stall_on && ($urandom_range(99) < 22);
  end

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    $display("%0t ERROR %s", $time, msg);
  endtask

  // Update the block table and work out the grant for one request.
  function automatic grant_t predict_grant(input logic [TYPE_W-1:0] kind,
                                           input logic [BIDX_W-1:0] idx,
                                           input logic [PSIZE_W-1:0] sz);
    grant_t g;
    int     active;
    int     pick;
    logic   found;
    g = '0;
    found = 1'b0;
    pick = 0;
    if (kind == REQ_LOAD) begin
      space_model[idx] = sz;
      g.space_left = sz;
    end else begin
      active = (count_model > BLOCKS) ? BLOCKS : int'(count_model);
      for (int j = 0; j < active; j++) begin
        if (space_model[j] >= sz) begin
          if (!found) begin
            found = 1'b1;
            pick = j;
          end else if (policy_model == POLICY_BEST && space_model[j] < space_model[pick]) begin
            pick = j;
          end else if (policy_model == POLICY_WORST && space_model[j] > space_model[pick]) begin
            pick = j;
          end
        end
      end
      if (found) begin
        space_model[pick] = space_model[pick] - sz;
        g.granted = 1'b1;
        g.chosen_block = pick[BIDX_W-1:0];
        g.space_left = space_model[pick];
      end
    end
    return g;
  endfunction

  // Call at a rising edge; returns at the edge where the request was taken.
  task automatic send_request(input logic [TYPE_W-1:0] kind, input logic [BIDX_W-1:0] idx,
                              input logic [PSIZE_W-1:0] sz);
    while (gaps_on && $urandom_range(99) < 22) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    req_type <= kind;
    block_index <= idx;
    size <= sz;
    do @(posedge clk); while (in_stall);
    grant_q.push_back(predict_grant(kind, idx, sz));
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    while (grant_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DAT_W-1:0] data);
    wait_results_done();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_FIT_POLICY) policy_model = data[POLICY_W-1:0];
    else count_model = data[BCOUNT_W-1:0];
  endtask

  always @(posedge clk) begin
    grant_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (grant_q.size() == 0) begin
        report_mismatch($sformatf("result with no request pending: granted %0d block %0d space %0d",
                                  granted, chosen_block, space_left));
      end else begin
        want = grant_q.pop_front();
        if (granted !== want.granted)
          report_mismatch($sformatf("granted: expected %0d, got %0d", want.granted, granted));
        if (chosen_block !== want.chosen_block)
          report_mismatch($sformatf("chosen_block: expected %0d, got %0d",
                                    want.chosen_block, chosen_block));
        if (space_left !== want.space_left)
          report_mismatch($sformatf("space_left: expected %0d, got %0d",
                                    want.space_left, space_left));
      end
    end
  end

  // Load every block, then walk each policy, ties, zero and full-size requests,
  // no-fit, an empty and a saturated block count.
  task automatic test_directed_fits();
    int unsigned load_sizes [BLOCKS] = '{100, 300, 200, 300, 65535, 0, 200, 50,
                                         1000, 1000, 5, 65535, 7, 12, 300, 40};
    for (int i = 0; i < BLOCKS; i++) begin
      send_request(REQ_LOAD, i[BIDX_W-1:0], PSIZE_W'(load_sizes[i]));
    end
    send_request(REQ_ALLOC, '1, 16'd150);
    send_request(REQ_ALLOC, '0, '1);
    write_config(CFG_FIT_POLICY, CFG_DAT_W'(POLICY_BEST));
    send_request(REQ_ALLOC, 4'd7, 16'd200);
    write_config(CFG_FIT_POLICY, CFG_DAT_W'(POLICY_WORST));
    send_request(REQ_ALLOC, 4'd2, '0);
    write_config(CFG_FIT_POLICY, CFG_DAT_W'(POLICY_ALT));
    send_request(REQ_ALLOC, 4'd9, 16'd10);
    write_config(CFG_BLOCK_COUNT, 5'd0);
    send_request(REQ_ALLOC, 4'd0, '0);
    write_config(CFG_BLOCK_COUNT, 5'd31);
    send_request(REQ_ALLOC, 4'd5, 16'd1000);
    write_config(CFG_BLOCK_COUNT, 5'd1);
    send_request(REQ_ALLOC, 4'd3, 16'd200);
    write_config(CFG_BLOCK_COUNT, 5'd16);
    send_request(REQ_ALLOC, 4'd1, '1);
  endtask

  task automatic test_random_phases();
    logic [POLICY_W-1:0] phase_policy [PHASES] = '{POLICY_FIRST, POLICY_BEST, POLICY_WORST,
                                                   POLICY_ALT, POLICY_BEST, POLICY_WORST,
                                                   POLICY_FIRST, POLICY_BEST, POLICY_WORST,
                                                   POLICY_ALT, POLICY_BEST, POLICY_WORST};
    int                  phase_count [PHASES] = '{16, 1, 31, 16, 0, 16, 9, 20, 2, 16, 15, 16};
    int                  active;
    int                  j;
    int                  roll;
    logic [PSIZE_W-1:0]  sz;
    for (int p = 0; p < PHASES; p++) begin
      // spare upper bits of the policy write must be ignored
      write_config(CFG_FIT_POLICY, {3'($urandom_range(7)), phase_policy[p]});
      write_config(CFG_BLOCK_COUNT, phase_count[p][BCOUNT_W-1:0]);
      gaps_on = (p != 6);
      stall_on = (p != 6);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if ($urandom_range(99) < 3) wait_results_done();
        active = (count_model > BLOCKS) ? BLOCKS : int'(count_model);
        j = (active > 0) ? $urandom_range(active - 1) : $urandom_range(BLOCKS - 1);
        roll = $urandom_range(99);
        if (roll < 30) begin
          case ($urandom_range(4))
            0:       sz = '0;
            1:       sz = '1;
            2:       sz = space_model[$urandom_range(BLOCKS - 1)];  // make ties
            3:       sz = PSIZE_W'($urandom_range(255));
            default: sz = PSIZE_W'($urandom_range(65535));
          endcase
          send_request(REQ_LOAD, BIDX_W'($urandom_range(BLOCKS - 1)), sz);
        end else begin
          if (roll < 75) sz = PSIZE_W'($urandom_range(space_model[j]));
          else if (roll < 85) sz = space_model[j] + 1'b1;
          else if (roll < 90) sz = $urandom_range(1) ? '1 : '0;
          else sz = PSIZE_W'($urandom_range(65535));
          send_request(REQ_ALLOC, BIDX_W'($urandom_range(BLOCKS - 1)), sz);
        end
      end
    end
    gaps_on = 1'b1;
    stall_on = 1'b1;
  endtask

  initial begin
    for (int i = 0; i < BLOCKS; i++) space_model[i] = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_fits();
    test_random_phases();
    wait_results_done();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0) $display("*** PASSED ***");
    else $display("*** FAILED ***");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results pending", grant_q.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule

>>> sim.f
src/fpba_pkg.sv
src/fpba_cell.sv
src/fit_policy_block_allocator.sv
src/fpba_checker.sv
test/testbench.sv
